// ===== hw/rtl/tksel_pkg.sv =====
// ----------------------------------------------------------------------------
// tksel_pkg
// Shared widths, constants and command and status types of the top-k score selector.
// ----------------------------------------------------------------------------
package tksel_pkg;

	localparam int SCORE_W    = 32;
	localparam int INDEX_W    = 32;
	localparam int RANK_W     = 4;
	localparam int TOPC_W     = 5;
	localparam logic [TOPC_W-1:0] TOPC_RESET = 5'd10;

	localparam int IN_TDATA_W  = SCORE_W + INDEX_W;
	localparam int OUT_FIELD_W = RANK_W + SCORE_W + INDEX_W;
	localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
	localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

	// controller -> datapath
	typedef struct packed {
		logic ins;  // request accepted: insert into the row if it qualifies
		logic pop;  // move row head into the output register
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic fill_one;  // exactly one entry left in the row
	} dp_stat_t;

endpackage

// ===== hw/rtl/top_k_score_selector_core.sv =====
// ----------------------------------------------------------------------------
// top_k_score_selector_core
// Streaming top-k selection over (score, index) requests.
// ----------------------------------------------------------------------------
// Input stream s_*: one request per accepted beat, score in s_tdata[31:0],
// index in s_tdata[63:32], s_tlast marks the final request of a pass.
// While a pass is open one request is taken every cycle; the compare-and-shift
// row places it in sorted position in the same cycle if it ranks in the top k.
// After the request with s_tlast, s_tready drops and the table drains through
// m_*: one result per cycle, best score first, rank in m_tdata[3:0], m_tlast
// on the final one. The first result is valid once the state register has
// entered the drain and the first pop has loaded the output register; a pass
// with n kept entries holds the input until all n are popped from the row head.
// A stall on m_tready holds the output register and pauses the drain; once
// the final result sits in the output register, new requests are taken.
// cfg_we/cfg_wdata write top_count (k, clamped to 1..MAX_TOP); write only
// while no pass is draining. Reset empties the table and sets k to 10.
// ----------------------------------------------------------------------------
module top_k_score_selector_core #(
	parameter int MAX_TOP = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [tksel_pkg::TOPC_W-1:0]         cfg_wdata,    // top_count
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [tksel_pkg::IN_TDATA_W-1:0]     s_tdata,      // score_key, item_index
	input  logic                                 s_tlast,      // end_of_pass
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [tksel_pkg::OUT_TDATA_W-1:0]    m_tdata,      // rank_position, out_score,
	                                                           // out_index, zero pad
	output logic                                 m_tlast       // last_result
);

	tksel_pkg::dp_cmd_t  cmd;
	tksel_pkg::dp_stat_t stat;

	logic [tksel_pkg::RANK_W-1:0]  out_rank;
	logic [tksel_pkg::SCORE_W-1:0] out_score;
	logic [tksel_pkg::INDEX_W-1:0] out_index;

	tksel_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	tksel_datapath #(
		.MAX_TOP (MAX_TOP)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_score  (s_tdata[tksel_pkg::SCORE_W-1:0]),
		.in_index  (s_tdata[tksel_pkg::IN_TDATA_W-1:tksel_pkg::SCORE_W]),
		.cmd       (cmd),
		.stat      (stat),
		.out_rank  (out_rank),
		.out_score (out_score),
		.out_index (out_index),
		.out_last  (m_tlast)
	);

	assign m_tdata = {{tksel_pkg::OUT_PAD_W{1'b0}}, out_index, out_score, out_rank};

endmodule

// ===== hw/rtl/tksel_ctrl.sv =====
// ----------------------------------------------------------------------------
// tksel_ctrl
// Pass controller: accepts requests, then drains the table into the output
// register one entry per cycle while m_tready does not stall it.
// ----------------------------------------------------------------------------
module tksel_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	input  logic               s_tlast,
	output logic               s_tready,
	output logic               m_tvalid,
	input  logic               m_tready,
	input  tksel_pkg::dp_stat_t stat,
	output tksel_pkg::dp_cmd_t  cmd
);

	typedef enum logic {
		ST_FILL,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	always_comb begin
		s_tready = (state_q == ST_FILL);
		cmd.ins  = s_tvalid && (state_q == ST_FILL);
		cmd.pop  = (state_q == ST_EMIT) && (!out_valid_q || m_tready);
	end

	assign m_tvalid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_FILL;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= cmd.pop || (out_valid_q && !m_tready);
			case (state_q)
				ST_FILL: begin
					if (cmd.ins && s_tlast) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (cmd.pop && stat.fill_one) begin
						state_q <= ST_FILL;
					end
				end
				default: begin
					state_q <= ST_FILL;
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	// no new request may be taken while the table drains
	a_no_ins_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> !cmd.ins)
		else $error("request taken during drain");
	// a held result must not be overwritten
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |-> !cmd.pop)
		else $error("pop over stalled result");
	// end of pass always leads into a drain
	a_eop_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.ins && s_tlast) |=> (state_q == ST_EMIT))
		else $error("end of pass did not start drain");
`endif

endmodule

// ===== hw/rtl/tksel_datapath.sv =====
// ----------------------------------------------------------------------------
// tksel_datapath
// Compare-and-shift row holding the best entries in descending order, the
// fill, top_count and rank registers and the output payload register.
// ----------------------------------------------------------------------------
module tksel_datapath #(
	parameter int MAX_TOP = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [tksel_pkg::TOPC_W-1:0]    cfg_wdata,
	input  logic [tksel_pkg::SCORE_W-1:0]   in_score,
	input  logic [tksel_pkg::INDEX_W-1:0]   in_index,
	input  tksel_pkg::dp_cmd_t              cmd,
	output tksel_pkg::dp_stat_t             stat,
	output logic [tksel_pkg::RANK_W-1:0]    out_rank,
	output logic [tksel_pkg::SCORE_W-1:0]   out_score,
	output logic [tksel_pkg::INDEX_W-1:0]   out_index,
	output logic                            out_last
);

	localparam int FW = $clog2(MAX_TOP + 1);
	localparam int CW = (FW > tksel_pkg::TOPC_W) ? FW : tksel_pkg::TOPC_W;

	logic [tksel_pkg::SCORE_W-1:0] score_q [MAX_TOP];
	logic [tksel_pkg::INDEX_W-1:0] index_q [MAX_TOP];
	logic [tksel_pkg::SCORE_W-1:0] up_score [MAX_TOP];
	logic [tksel_pkg::INDEX_W-1:0] up_index [MAX_TOP];
	logic [tksel_pkg::SCORE_W-1:0] dn_score [MAX_TOP];
	logic [tksel_pkg::INDEX_W-1:0] dn_index [MAX_TOP];

	logic [tksel_pkg::TOPC_W-1:0] top_count_q;
	logic [FW-1:0]                fill_q;
	logic [tksel_pkg::RANK_W-1:0] rank_q;

	logic [FW-1:0]      k;
	logic [FW-1:0]      fill_eff;
	logic [MAX_TOP-1:0] ge;
	logic [MAX_TOP-1:0] prev_ge;
	logic               last_ge;
	logic               do_ins;

	// neighbor taps of each cell; row ends take the new item / hold
	for (genvar g = 0; g < MAX_TOP; g++) begin : g_tap
		if (g == 0) begin : g_first
			assign up_score[g] = in_score;
			assign up_index[g] = in_index;
		end else begin : g_mid
			assign up_score[g] = score_q[g-1];
			assign up_index[g] = index_q[g-1];
		end
		if (g == MAX_TOP - 1) begin : g_end
			assign dn_score[g] = score_q[g];
			assign dn_index[g] = index_q[g];
		end else begin : g_inner
			assign dn_score[g] = score_q[g+1];
			assign dn_index[g] = index_q[g+1];
		end
	end

	always_comb begin
		// effective k: top_count clamped to 1..MAX_TOP
		if (top_count_q == '0) begin
			k = FW'(1);
		end else if (CW'(top_count_q) > CW'(MAX_TOP)) begin
			k = FW'(MAX_TOP);
		end else begin
			k = FW'(top_count_q);
		end
		fill_eff = (fill_q > k) ? k : fill_q;

		// entries at or above the new score form a prefix of the row
		last_ge = 1'b0;
		for (int i = 0; i < MAX_TOP; i++) begin
			ge[i] = (FW'(i) < fill_eff) && (score_q[i] >= in_score);
			if (FW'(i) == k - FW'(1)) begin
				last_ge = ge[i];
			end
		end
		prev_ge[0] = 1'b1;
		for (int i = 1; i < MAX_TOP; i++) begin
			prev_ge[i] = ge[i-1];
		end
		// full table: only a strictly greater score gets in
		do_ins = (fill_eff < k) || !last_ge;
	end

	assign stat.fill_one = (fill_q == FW'(1));

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_TOP; i++) begin
			if (cmd.ins && do_ins && !ge[i]) begin
				score_q[i] <= prev_ge[i] ? in_score : up_score[i];
				index_q[i] <= prev_ge[i] ? in_index : up_index[i];
			end else if (cmd.pop) begin
				score_q[i] <= dn_score[i];
				index_q[i] <= dn_index[i];
			end
		end
		if (cmd.pop) begin
			out_score <= score_q[0];
			out_index <= index_q[0];
			out_rank  <= rank_q;
			out_last  <= stat.fill_one;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_count_q <= tksel_pkg::TOPC_RESET;
			fill_q      <= '0;
			rank_q      <= '0;
		end else begin
			if (cfg_we) begin
				top_count_q <= cfg_wdata;
			end
			if (cmd.ins) begin
				if (do_ins && (fill_eff < k)) begin
					fill_q <= fill_eff + FW'(1);
				end else begin
					fill_q <= fill_eff;
				end
			end else if (cmd.pop) begin
				fill_q <= fill_q - FW'(1);
				rank_q <= stat.fill_one ? '0 : rank_q + tksel_pkg::RANK_W'(1);
			end
		end
	end

`ifndef ASSERT_OFF
	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.ins && cmd.pop))
		else $error("insert and pop in the same cycle");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> (fill_q != '0))
		else $error("pop from empty row");
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins |=> (fill_q <= k))
		else $error("fill count beyond k after insert");
	a_rank_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.pop && stat.fill_one) |=> (rank_q == '0))
		else $error("rank not restarted after last result");
`endif

endmodule
